[hdl/cpu6502_subset_instruction_step_macros.svh]
// assertion macros used by c6step_seq
`ifndef CPU6502_SUBSET_INSTRUCTION_STEP_MACROS_SVH
`define CPU6502_SUBSET_INSTRUCTION_STEP_MACROS_SVH

// implication checked on every clock edge outside reset
`define C6_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define C6_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/c6step_pkg.sv]
// ----------------------------------------------------------------------------
// c6step_pkg
// shared types and constants of the subset 6502 step block
// ----------------------------------------------------------------------------
`default_nettype none

package c6step_pkg;

  localparam int unsigned AddrW = 16;
  localparam int unsigned MemDepth = 65536;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_START = 2'd2,
    CMD_STEP  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BRK     = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_REFUSED = 2'd3
  } status_e;

  localparam logic [7:0] OP_LDA_IMM = 8'hA9;
  localparam logic [7:0] OP_LDA_ZP  = 8'hA5;
  localparam logic [7:0] OP_LDA_ABX = 8'hBD;
  localparam logic [7:0] OP_STA_ABS = 8'h8D;
  localparam logic [7:0] OP_STA_ZP  = 8'h85;
  localparam logic [7:0] OP_STA_ABX = 8'h9D;
  localparam logic [7:0] OP_LDX_IMM = 8'hA2;
  localparam logic [7:0] OP_STX_ABS = 8'h8E;
  localparam logic [7:0] OP_TAX     = 8'hAA;
  localparam logic [7:0] OP_INX     = 8'hE8;
  localparam logic [7:0] OP_DEX     = 8'hCA;
  localparam logic [7:0] OP_CMP_IMM = 8'hC9;
  localparam logic [7:0] OP_CPX_IMM = 8'hE0;
  localparam logic [7:0] OP_ADC_IMM = 8'h69;
  localparam logic [7:0] OP_ADC_ZP  = 8'h65;
  localparam logic [7:0] OP_INC_ZP  = 8'hE6;
  localparam logic [7:0] OP_BNE     = 8'hD0;
  localparam logic [7:0] OP_BEQ     = 8'hF0;
  localparam logic [7:0] OP_BCS     = 8'hB0;
  localparam logic [7:0] OP_BCC     = 8'h90;
  localparam logic [7:0] OP_JMP     = 8'h4C;
  localparam logic [7:0] OP_JSR     = 8'h20;
  localparam logic [7:0] OP_RTS     = 8'h60;
  localparam logic [7:0] OP_BRK     = 8'h00;

  localparam logic [15:0] ResetVector = 16'hFFFC;
  localparam logic [7:0]  StackPage   = 8'h01;
  localparam logic [7:0]  SpReset     = 8'hFF;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RDWAIT, S_VEC_LO, S_VEC_HI, S_OP, S_B1, S_B2,
    S_DATA, S_DATA2, S_RESP
  } state_e;

  // memory request from the sequencer
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    logic [7:0]       wdata;
  } mem_req_t;

endpackage

`default_nettype wire

[hdl/c6step_ram.sv]
// ----------------------------------------------------------------------------
// c6step_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module c6step_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

[hdl/c6step_seq.sv]
// ----------------------------------------------------------------------------
// c6step_seq
// command and instruction sequencer, at most one memory access per cycle
// ----------------------------------------------------------------------------
`default_nettype none

`include "cpu6502_subset_instruction_step_macros.svh"

module c6step_seq (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output      logic                   in_ready_o,
  input  wire logic [1:0]             command_i,
  input  wire logic [15:0]            address_i,
  input  wire logic [7:0]             data_i,
  output      logic                   out_valid_o,
  input  wire logic                   out_ready_i,
  output      logic [1:0]             status_o,
  output      logic [15:0]            pc_now_o,
  output      logic [7:0]             acc_now_o,
  output      logic [7:0]             x_now_o,
  output      logic [7:0]             sp_now_o,
  output      logic [3:0]             flags_now_o,
  output      logic [7:0]             read_byte_o,
  output      c6step_pkg::mem_req_t   mem_req_o,
  input  wire logic [7:0]             mem_rdata_i
);

  c6step_pkg::state_e state_q, state_d;
  logic [15:0] pc_q, pc_d, clr_q, clr_d, w_q, w_d;
  logic [7:0]  a_q, a_d, x_q, x_d, sp_q, sp_d, op_q, op_d, b1_q, b1_d, rb_q, rb_d;
  logic [3:0]  fl_q, fl_d;
  logic        halt_q, halt_d;
  logic [1:0]  st_q, st_d;
  logic [16:0] clr_next;
  logic [8:0]  sum;
  logic [7:0]  res, diff;
  logic [15:0] bt;

  assign clr_next = {1'b0, clr_q} + 17'd1;
  assign bt = pc_q + 16'd2 + {{8{b1_q[7]}}, b1_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= c6step_pkg::S_CLEAR;
      clr_q <= '0; pc_q <= '0; a_q <= '0; x_q <= '0;
      sp_q <= c6step_pkg::SpReset; fl_q <= '0; halt_q <= 1'b1; st_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d; pc_q <= pc_d; a_q <= a_d; x_q <= x_d;
      sp_q <= sp_d; fl_q <= fl_d; halt_q <= halt_d; st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d; op_q <= op_d; b1_q <= b1_d; rb_q <= rb_d;
  end

  always_comb begin
    state_d = state_q;
    clr_d = clr_q; pc_d = pc_q; a_d = a_q; x_d = x_q; sp_d = sp_q;
    fl_d = fl_q; halt_d = halt_q; st_d = st_q;
    w_d = w_q; op_d = op_q; b1_d = b1_q; rb_d = rb_q;
    mem_req_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    sum = '0; res = '0; diff = '0;
    case (state_q)
      c6step_pkg::S_CLEAR: begin
        mem_req_o.we = 1'b1;
        mem_req_o.addr = clr_q;
        clr_d = clr_next[15:0];
        if (clr_next[16]) state_d = c6step_pkg::S_IDLE;
      end
      c6step_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        st_d = c6step_pkg::ST_OK;
        rb_d = '0;
        if (in_valid_i) begin
          case (command_i)
            c6step_pkg::CMD_WRITE: begin
              mem_req_o.we = 1'b1;
              mem_req_o.addr = address_i;
              mem_req_o.wdata = data_i;
              state_d = c6step_pkg::S_RESP;
            end
            c6step_pkg::CMD_READ: begin
              mem_req_o.addr = address_i;
              state_d = c6step_pkg::S_RDWAIT;
            end
            c6step_pkg::CMD_START: begin
              mem_req_o.addr = c6step_pkg::ResetVector;
              state_d = c6step_pkg::S_VEC_LO;
            end
            default: begin
              if (halt_q) begin
                st_d = c6step_pkg::ST_REFUSED;
                state_d = c6step_pkg::S_RESP;
              end else begin
                mem_req_o.addr = pc_q;
                state_d = c6step_pkg::S_OP;
              end
            end
          endcase
        end
      end
      c6step_pkg::S_RDWAIT: begin
        rb_d = mem_rdata_i;
        state_d = c6step_pkg::S_RESP;
      end
      c6step_pkg::S_VEC_LO: begin
        w_d[7:0] = mem_rdata_i;
        mem_req_o.addr = c6step_pkg::ResetVector + 16'd1;
        state_d = c6step_pkg::S_VEC_HI;
      end
      c6step_pkg::S_VEC_HI: begin
        pc_d = {mem_rdata_i, w_q[7:0]};
        halt_d = 1'b0;
        state_d = c6step_pkg::S_RESP;
      end
      c6step_pkg::S_OP: begin
        op_d = mem_rdata_i;
        mem_req_o.addr = pc_q + 16'd1;
        state_d = c6step_pkg::S_B1;
        case (mem_rdata_i)
          c6step_pkg::OP_TAX: begin
            x_d = a_q; fl_d[3] = a_q[7]; fl_d[1] = (a_q == 8'h00);
            pc_d = pc_q + 16'd1; state_d = c6step_pkg::S_RESP;
          end
          c6step_pkg::OP_INX, c6step_pkg::OP_DEX: begin
            res = (mem_rdata_i == c6step_pkg::OP_INX) ? x_q + 8'd1 : x_q - 8'd1;
            x_d = res; fl_d[3] = res[7]; fl_d[1] = (res == 8'h00);
            pc_d = pc_q + 16'd1; state_d = c6step_pkg::S_RESP;
          end
          c6step_pkg::OP_RTS: begin
            mem_req_o.addr = {c6step_pkg::StackPage, sp_q + 8'd1};
            sp_d = sp_q + 8'd1;
          end
          c6step_pkg::OP_JSR: begin
            mem_req_o.addr = pc_q + 16'd1;
          end
          c6step_pkg::OP_LDA_IMM, c6step_pkg::OP_LDA_ZP, c6step_pkg::OP_LDA_ABX,
          c6step_pkg::OP_STA_ABS, c6step_pkg::OP_STA_ZP, c6step_pkg::OP_STA_ABX,
          c6step_pkg::OP_LDX_IMM, c6step_pkg::OP_STX_ABS, c6step_pkg::OP_CMP_IMM,
          c6step_pkg::OP_CPX_IMM, c6step_pkg::OP_ADC_IMM, c6step_pkg::OP_ADC_ZP,
          c6step_pkg::OP_INC_ZP, c6step_pkg::OP_BNE, c6step_pkg::OP_BEQ,
          c6step_pkg::OP_BCS, c6step_pkg::OP_BCC, c6step_pkg::OP_JMP: begin
          end
          default: begin
            halt_d = 1'b1;
            st_d = (mem_rdata_i == c6step_pkg::OP_BRK) ? c6step_pkg::ST_BRK
                                                         : c6step_pkg::ST_UNKNOWN;
            pc_d = pc_q + 16'd1;
            state_d = c6step_pkg::S_RESP;
          end
        endcase
      end
      c6step_pkg::S_B1: begin
        b1_d = mem_rdata_i;
        w_d[7:0] = mem_rdata_i;
        state_d = c6step_pkg::S_RESP;
        case (op_q)
          c6step_pkg::OP_LDA_IMM, c6step_pkg::OP_LDX_IMM: begin
            if (op_q == c6step_pkg::OP_LDA_IMM) a_d = mem_rdata_i;
            else x_d = mem_rdata_i;
            fl_d[3] = mem_rdata_i[7]; fl_d[1] = (mem_rdata_i == 8'h00);
            pc_d = pc_q + 16'd2;
          end
          c6step_pkg::OP_CMP_IMM, c6step_pkg::OP_CPX_IMM: begin
            res = (op_q == c6step_pkg::OP_CMP_IMM) ? a_q : x_q;
            diff = res - mem_rdata_i;
            fl_d[0] = (res >= mem_rdata_i); fl_d[1] = (res == mem_rdata_i);
            fl_d[3] = diff[7];
            pc_d = pc_q + 16'd2;
          end
          c6step_pkg::OP_ADC_IMM: begin
            sum = {1'b0, a_q} + {1'b0, mem_rdata_i} + {8'h00, fl_q[0]};
            a_d = sum[7:0]; fl_d[0] = sum[8];
            fl_d[2] = ~(a_q[7] ^ mem_rdata_i[7]) & (a_q[7] ^ sum[7]);
            fl_d[3] = sum[7]; fl_d[1] = (sum[7:0] == 8'h00);
            pc_d = pc_q + 16'd2;
          end
          c6step_pkg::OP_STA_ZP: begin
            mem_req_o.we = 1'b1; mem_req_o.addr = {8'h00, mem_rdata_i};
            mem_req_o.wdata = a_q; pc_d = pc_q + 16'd2;
          end
          c6step_pkg::OP_LDA_ZP, c6step_pkg::OP_ADC_ZP, c6step_pkg::OP_INC_ZP: begin
            mem_req_o.addr = {8'h00, mem_rdata_i};
            state_d = c6step_pkg::S_DATA;
          end
          c6step_pkg::OP_BNE, c6step_pkg::OP_BEQ, c6step_pkg::OP_BCS,
          c6step_pkg::OP_BCC: begin
            state_d = c6step_pkg::S_DATA;
          end
          c6step_pkg::OP_RTS: begin
            mem_req_o.addr = {c6step_pkg::StackPage, sp_q + 8'd1};
            sp_d = sp_q + 8'd1;
            state_d = c6step_pkg::S_DATA;
          end
          default: begin
            mem_req_o.addr = pc_q + 16'd2;
            state_d = c6step_pkg::S_B2;
          end
        endcase
      end
      c6step_pkg::S_B2: begin
        w_d[15:8] = mem_rdata_i;
        state_d = c6step_pkg::S_RESP;
        pc_d = pc_q + 16'd3;
        case (op_q)
          c6step_pkg::OP_STA_ABS, c6step_pkg::OP_STX_ABS: begin
            mem_req_o.we = 1'b1; mem_req_o.addr = {mem_rdata_i, w_q[7:0]};
            mem_req_o.wdata = (op_q == c6step_pkg::OP_STA_ABS) ? a_q : x_q;
          end
          c6step_pkg::OP_STA_ABX: begin
            mem_req_o.we = 1'b1;
            mem_req_o.addr = {mem_rdata_i, w_q[7:0]} + {8'h00, x_q};
            mem_req_o.wdata = a_q;
          end
          c6step_pkg::OP_LDA_ABX: begin
            mem_req_o.addr = {mem_rdata_i, w_q[7:0]} + {8'h00, x_q};
            state_d = c6step_pkg::S_DATA;
          end
          c6step_pkg::OP_JMP: begin
            pc_d = {mem_rdata_i, w_q[7:0]};
          end
          default: begin
            // jsr: push return high byte
            mem_req_o.we = 1'b1;
            mem_req_o.addr = {c6step_pkg::StackPage, sp_q};
            mem_req_o.wdata = pc_q[15:8] + {7'd0, (pc_q[7:0] > 8'hFD)};
            sp_d = sp_q - 8'd1;
            pc_d = pc_q;
            state_d = c6step_pkg::S_DATA2;
          end
        endcase
      end
      c6step_pkg::S_DATA: begin
        state_d = c6step_pkg::S_RESP;
        pc_d = pc_q + 16'd2;
        case (op_q)
          c6step_pkg::OP_LDA_ZP, c6step_pkg::OP_LDA_ABX: begin
            a_d = mem_rdata_i;
            fl_d[3] = mem_rdata_i[7]; fl_d[1] = (mem_rdata_i == 8'h00);
          end
          c6step_pkg::OP_ADC_ZP: begin
            sum = {1'b0, a_q} + {1'b0, mem_rdata_i} + {8'h00, fl_q[0]};
            a_d = sum[7:0]; fl_d[0] = sum[8];
            fl_d[2] = ~(a_q[7] ^ mem_rdata_i[7]) & (a_q[7] ^ sum[7]);
            fl_d[3] = sum[7]; fl_d[1] = (sum[7:0] == 8'h00);
          end
          c6step_pkg::OP_INC_ZP: begin
            res = mem_rdata_i + 8'd1;
            mem_req_o.we = 1'b1; mem_req_o.addr = {8'h00, b1_q};
            mem_req_o.wdata = res;
            fl_d[3] = res[7]; fl_d[1] = (res == 8'h00);
          end
          c6step_pkg::OP_BNE: if (!fl_q[1]) pc_d = bt;
          c6step_pkg::OP_BEQ: if (fl_q[1]) pc_d = bt;
          c6step_pkg::OP_BCS: if (fl_q[0]) pc_d = bt;
          c6step_pkg::OP_BCC: if (!fl_q[0]) pc_d = bt;
          default: begin
            // rts: low byte in b1, high byte arriving now
            pc_d = {mem_rdata_i, b1_q} + 16'd1;
          end
        endcase
        if (op_q == c6step_pkg::OP_LDA_ABX) pc_d = pc_q;
      end
      c6step_pkg::S_DATA2: begin
        // jsr: push return low byte and jump
        mem_req_o.we = 1'b1;
        mem_req_o.addr = {c6step_pkg::StackPage, sp_q};
        mem_req_o.wdata = pc_q[7:0] + 8'd2;
        sp_d = sp_q - 8'd1;
        pc_d = w_q;
        state_d = c6step_pkg::S_RESP;
      end
      c6step_pkg::S_RESP: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = c6step_pkg::S_IDLE;
      end
      default: state_d = c6step_pkg::S_IDLE;
    endcase
  end

  assign status_o = st_q;
  assign pc_now_o = pc_q;
  assign acc_now_o = a_q;
  assign x_now_o = x_q;
  assign sp_now_o = sp_q;
  assign flags_now_o = fl_q;
  assign read_byte_o = rb_q;

  `C6_ASSERT_IMPL(a_ready_idle, clk_i, rst_ni, in_ready_o,
    state_q == c6step_pkg::S_IDLE, "ready outside idle")
  `C6_ASSERT_IMPL(a_no_overlap, clk_i, rst_ni, in_ready_o, !out_valid_o,
    "accept while result pending")
  `C6_ASSERT_NEXT(a_refused_halt, clk_i, rst_ni,
    in_valid_i && in_ready_o && command_i == c6step_pkg::CMD_STEP && halt_q,
    st_q == c6step_pkg::ST_REFUSED, "halted step not refused")
  `C6_ASSERT_NEXT(a_start_runs, clk_i, rst_ni,
    state_q == c6step_pkg::S_VEC_HI, !halt_q, "start left core halted")

endmodule

`default_nettype wire

[hdl/cpu6502_subset_instruction_step.sv]
// ----------------------------------------------------------------------------
// cpu6502_subset_instruction_step
// subset 6502 core with a private 64 KiB memory, one command per transaction
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// in        input      in_valid/in_ready  command, address, data
// out       output     out_valid/out_ready status, pc/acc/x/sp/flags, read_byte
//
// one memory port, one access per cycle; it sets the instruction length.
// after reset the memory is cleared, one byte a cycle, and no input is taken until then.
// one transaction at a time; a stalled result holds the input side.
// ----------------------------------------------------------------------------
`default_nettype none

module cpu6502_subset_instruction_step (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [15:0] address_i,
  input  wire logic [7:0]  data_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [1:0]  status_o,
  output      logic [15:0] pc_now_o,
  output      logic [7:0]  acc_now_o,
  output      logic [7:0]  x_now_o,
  output      logic [7:0]  sp_now_o,
  output      logic [3:0]  flags_now_o,
  output      logic [7:0]  read_byte_o
);

  c6step_pkg::mem_req_t mem_req;
  logic [7:0] mem_rdata;

  c6step_seq u_seq (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .command_i, .address_i, .data_i,
    .out_valid_o, .out_ready_i, .status_o, .pc_now_o, .acc_now_o, .x_now_o,
    .sp_now_o, .flags_now_o, .read_byte_o,
    .mem_req_o(mem_req), .mem_rdata_i(mem_rdata)
  );

  c6step_ram #(
    .Width(8),
    .Depth(c6step_pkg::MemDepth)
  ) u_mem (
    .clk_i,
    .we_i(mem_req.we),
    .addr_i(mem_req.addr),
    .wdata_i(mem_req.wdata),
    .rdata_o(mem_rdata)
  );

endmodule

`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// subset 6502 step block testbench
// loads short programs, starts them from the reset vector and single-steps
// them; a scoreboard carries its own copy of memory and registers and checks
// every result field against its prediction, with random gaps and stalls
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  typedef struct {
    c6step_pkg::status_e st;
    logic [15:0] pc;
    logic [7:0]  acc;
    logic [7:0]  x;
    logic [7:0]  sp;
    logic [3:0]  flags;
    logic [7:0]  rd_byte;
  } cpu_view_t;

  localparam logic [3:0] FlagZ = 4'h2;
  localparam logic [3:0] FlagC = 4'h1;

  class c6_scoreboard;
    logic [7:0]  mem [0:65535];
    logic [7:0]  acc, xr, sp;
    logic [3:0]  flags;
    logic [15:0] pc;
    bit          halted;
    cpu_view_t   pending[$];
    int          mismatches;

    function new();
      foreach (mem[i]) mem[i] = 8'h00;
      acc = 0; xr = 0; sp = c6step_pkg::SpReset; flags = 0; pc = 0; halted = 1;
      mismatches = 0;
    endfunction

    function void set_nz(logic [7:0] v);
      flags[3] = v[7];
      flags[1] = (v == 8'h00);
    endfunction

    function void compare_reg(logic [7:0] r, logic [7:0] m);
      logic [7:0] d;
      d = r - m;
      flags[0] = (r >= m);
      flags[1] = (r == m);
      flags[3] = d[7];
    endfunction

    function void add_with_carry(logic [7:0] m);
      logic [8:0] s;
      logic [7:0] r;
      s = {1'b0, acc} + {1'b0, m} + {8'h00, flags[0]};
      r = s[7:0];
      flags[0] = s[8];
      flags[2] = ~(acc[7] ^ m[7]) & (acc[7] ^ r[7]);
      acc = r;
      set_nz(r);
    endfunction

    function c6step_pkg::status_e run_instruction();
      logic [7:0]  op, b1, lo, hi;
      logic [15:0] w, np, ret, tgt;
      c6step_pkg::status_e st;
      op = mem[pc];
      b1 = mem[pc + 16'd1];
      w  = {mem[pc + 16'd2], b1};
      np = pc + 16'd1;
      st = c6step_pkg::ST_OK;
      tgt = pc + 16'd2 + {{8{b1[7]}}, b1};
      case (op)
        c6step_pkg::OP_LDA_IMM: begin acc = b1; set_nz(acc); np = pc + 16'd2; end
        c6step_pkg::OP_LDA_ZP: begin
          acc = mem[{8'h00, b1}]; set_nz(acc); np = pc + 16'd2;
        end
        c6step_pkg::OP_LDA_ABX: begin
          acc = mem[w + {8'h00, xr}]; set_nz(acc); np = pc + 16'd3;
        end
        c6step_pkg::OP_STA_ABS: begin mem[w] = acc; np = pc + 16'd3; end
        c6step_pkg::OP_STA_ZP:  begin mem[{8'h00, b1}] = acc; np = pc + 16'd2; end
        c6step_pkg::OP_STA_ABX: begin mem[w + {8'h00, xr}] = acc; np = pc + 16'd3; end
        c6step_pkg::OP_LDX_IMM: begin xr = b1; set_nz(xr); np = pc + 16'd2; end
        c6step_pkg::OP_STX_ABS: begin mem[w] = xr; np = pc + 16'd3; end
        c6step_pkg::OP_TAX:     begin xr = acc; set_nz(xr); end
        c6step_pkg::OP_INX:     begin xr = xr + 8'd1; set_nz(xr); end
        c6step_pkg::OP_DEX:     begin xr = xr - 8'd1; set_nz(xr); end
        c6step_pkg::OP_CMP_IMM: begin compare_reg(acc, b1); np = pc + 16'd2; end
        c6step_pkg::OP_CPX_IMM: begin compare_reg(xr, b1); np = pc + 16'd2; end
        c6step_pkg::OP_ADC_IMM: begin add_with_carry(b1); np = pc + 16'd2; end
        c6step_pkg::OP_ADC_ZP: begin
          add_with_carry(mem[{8'h00, b1}]); np = pc + 16'd2;
        end
        c6step_pkg::OP_INC_ZP: begin
          mem[{8'h00, b1}] = mem[{8'h00, b1}] + 8'd1;
          set_nz(mem[{8'h00, b1}]);
          np = pc + 16'd2;
        end
        c6step_pkg::OP_BNE: np = (flags & FlagZ) == 0 ? tgt : pc + 16'd2;
        c6step_pkg::OP_BEQ: np = (flags & FlagZ) != 0 ? tgt : pc + 16'd2;
        c6step_pkg::OP_BCS: np = (flags & FlagC) != 0 ? tgt : pc + 16'd2;
        c6step_pkg::OP_BCC: np = (flags & FlagC) == 0 ? tgt : pc + 16'd2;
        c6step_pkg::OP_JMP: np = w;
        c6step_pkg::OP_JSR: begin
          ret = pc + 16'd2;
          mem[{c6step_pkg::StackPage, sp}] = ret[15:8];
          sp = sp - 8'd1;
          mem[{c6step_pkg::StackPage, sp}] = ret[7:0];
          sp = sp - 8'd1;
          np = w;
        end
        c6step_pkg::OP_RTS: begin
          sp = sp + 8'd1;
          lo = mem[{c6step_pkg::StackPage, sp}];
          sp = sp + 8'd1;
          hi = mem[{c6step_pkg::StackPage, sp}];
          np = {hi, lo} + 16'd1;
        end
        c6step_pkg::OP_BRK: begin st = c6step_pkg::ST_BRK; halted = 1; end
        default: begin st = c6step_pkg::ST_UNKNOWN; halted = 1; end
      endcase
      pc = np;
      return st;
    endfunction

    function void note_input(c6step_pkg::cmd_e c, logic [15:0] ad, logic [7:0] d);
      cpu_view_t e;
      e.st = c6step_pkg::ST_OK;
      e.rd_byte = 8'h00;
      case (c)
        c6step_pkg::CMD_WRITE: mem[ad] = d;
        c6step_pkg::CMD_READ:  e.rd_byte = mem[ad];
        c6step_pkg::CMD_START: begin
          pc = {mem[c6step_pkg::ResetVector + 16'd1], mem[c6step_pkg::ResetVector]};
          halted = 0;
        end
        default: begin
          if (halted) e.st = c6step_pkg::ST_REFUSED;
          else e.st = run_instruction();
        end
      endcase
      e.pc = pc; e.acc = acc; e.x = xr; e.sp = sp; e.flags = flags;
      pending.push_back(e);
    endfunction

    function void check_result(cpu_view_t got);
      cpu_view_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result pc=%h", got.pc);
        return;
      end
      e = pending.pop_front();
      if (got.st !== e.st || got.pc !== e.pc || got.acc !== e.acc || got.x !== e.x ||
          got.sp !== e.sp || got.flags !== e.flags || got.rd_byte !== e.rd_byte) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch exp st=%0d pc=%h a=%h x=%h sp=%h f=%h rb=%h,",
                    " got st=%0d pc=%h a=%h x=%h sp=%h f=%h rb=%h"},
                   e.st, e.pc, e.acc, e.x, e.sp, e.flags, e.rd_byte,
                   got.st, got.pc, got.acc, got.x, got.sp, got.flags, got.rd_byte);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  command = c6step_pkg::CMD_WRITE;
  logic [15:0] address = 16'h0;
  logic [7:0]  data = 8'h0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [15:0] pc_now;
  logic [7:0]  acc_now, x_now, sp_now, read_byte;
  logic [3:0]  flags_now;

  c6_scoreboard sb = new();
  int  burst_left = 0;
  int  items_sent = 0;
  bit  holdoff_req = 0;
  int  idle_cycles = 0;
  logic [7:0] prog[$];

  localparam int WatchdogLimit = 200000;

  always #2 clk_i = ~clk_i;

  cpu6502_subset_instruction_step dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .command_i(command), .address_i(address), .data_i(data),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .status_o(status), .pc_now_o(pc_now), .acc_now_o(acc_now), .x_now_o(x_now),
    .sp_now_o(sp_now), .flags_now_o(flags_now), .read_byte_o(read_byte)
  );

  // check first, then record the transaction accepted on the same edge
  always @(posedge clk_i) begin
    cpu_view_t got;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        got.st = c6step_pkg::status_e'(status); got.pc = pc_now; got.acc = acc_now;
        got.x = x_now; got.sp = sp_now; got.flags = flags_now; got.rd_byte = read_byte;
        sb.check_result(got);
      end
      if (in_valid && in_ready) sb.note_input(c6step_pkg::cmd_e'(command), address, data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int mode, seg;
    forever begin
      if (holdoff_req) begin
        @(posedge clk_i);
        out_ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        holdoff_req = 0;
      end
      mode = $urandom_range(0, 2);
      seg  = $urandom_range(10, 80);
      repeat (seg) begin
        @(posedge clk_i);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send(c6step_pkg::cmd_e c, logic [15:0] ad, logic [7:0] d);
    in_valid <= 1'b1;
    command  <= c;
    address  <= ad;
    data     <= d;
    do @(posedge clk_i); while (!in_ready);
    items_sent++;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic load_and_run(logic [15:0] base, int steps);
    foreach (prog[i]) send(c6step_pkg::CMD_WRITE, base + 16'(i), prog[i]);
    send(c6step_pkg::CMD_WRITE, c6step_pkg::ResetVector, base[7:0]);
    send(c6step_pkg::CMD_WRITE, c6step_pkg::ResetVector + 16'd1, base[15:8]);
    send(c6step_pkg::CMD_START, 16'($urandom), 8'($urandom));
    repeat (steps) send(c6step_pkg::CMD_STEP, 16'($urandom), 8'($urandom));
  endtask

  // append one random instruction; jumps mostly land inside the program
  task automatic add_random_instr(logic [15:0] base);
    logic [7:0] ops [24] = '{c6step_pkg::OP_LDA_IMM, c6step_pkg::OP_LDA_ZP,
      c6step_pkg::OP_LDA_ABX, c6step_pkg::OP_STA_ABS, c6step_pkg::OP_STA_ZP,
      c6step_pkg::OP_STA_ABX, c6step_pkg::OP_LDX_IMM, c6step_pkg::OP_STX_ABS,
      c6step_pkg::OP_TAX, c6step_pkg::OP_INX, c6step_pkg::OP_DEX, c6step_pkg::OP_CMP_IMM,
      c6step_pkg::OP_CPX_IMM, c6step_pkg::OP_ADC_IMM, c6step_pkg::OP_ADC_ZP,
      c6step_pkg::OP_INC_ZP, c6step_pkg::OP_BNE, c6step_pkg::OP_BEQ, c6step_pkg::OP_BCS,
      c6step_pkg::OP_BCC, c6step_pkg::OP_JMP, c6step_pkg::OP_JSR, c6step_pkg::OP_RTS,
      c6step_pkg::OP_BRK};
    logic [7:0]  op;
    logic [15:0] w;
    op = ($urandom_range(0, 29) == 0) ? 8'($urandom) : ops[$urandom_range(0, 22)];
    if ($urandom_range(0, 40) == 0) op = c6step_pkg::OP_BRK;
    prog.push_back(op);
    w = 16'($urandom);
    if (op == c6step_pkg::OP_JMP || op == c6step_pkg::OP_JSR) begin
      if ($urandom_range(0, 3) != 0) w = base + 16'($urandom_range(0, 20));
    end else if (op == c6step_pkg::OP_BNE || op == c6step_pkg::OP_BEQ ||
                 op == c6step_pkg::OP_BCS || op == c6step_pkg::OP_BCC) begin
      w[7:0] = ($urandom_range(0, 3) != 0) ? 8'($signed($urandom_range(0, 12)) - 6)
                                           : 8'($urandom);
    end
    case (op)
      c6step_pkg::OP_LDA_ABX, c6step_pkg::OP_STA_ABS, c6step_pkg::OP_STA_ABX,
      c6step_pkg::OP_STX_ABS, c6step_pkg::OP_JMP, c6step_pkg::OP_JSR: begin
        prog.push_back(w[7:0]); prog.push_back(w[15:8]);
      end
      c6step_pkg::OP_TAX, c6step_pkg::OP_INX, c6step_pkg::OP_DEX, c6step_pkg::OP_RTS,
      c6step_pkg::OP_BRK: ;
      default: prog.push_back(w[7:0]);
    endcase
  endtask

  initial begin
    logic [15:0] base;
    int n, pick;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corners: refused step before start, extreme addresses and data
    send(c6step_pkg::CMD_STEP, 16'hFFFF, 8'hFF);
    send(c6step_pkg::CMD_READ, 16'hFFFF, 8'h00);
    send(c6step_pkg::CMD_WRITE, 16'h0000, 8'hFF);
    send(c6step_pkg::CMD_READ, 16'h0000, 8'hFF);
    // program holding every opcode: signed overflow, wrapping abs,X, brk halt
    prog = '{c6step_pkg::OP_LDA_IMM, 8'h7F, c6step_pkg::OP_ADC_IMM, 8'h01,
             c6step_pkg::OP_TAX, c6step_pkg::OP_DEX, c6step_pkg::OP_INX,
             c6step_pkg::OP_CPX_IMM, 8'h81, c6step_pkg::OP_CMP_IMM, 8'h80,
             c6step_pkg::OP_ADC_ZP, 8'h00, c6step_pkg::OP_STA_ZP, 8'hFE,
             c6step_pkg::OP_INC_ZP, 8'hFE, c6step_pkg::OP_LDA_ZP, 8'hFE,
             c6step_pkg::OP_LDX_IMM, 8'hFF,
             c6step_pkg::OP_STA_ABX, 8'hFF, 8'hFF, c6step_pkg::OP_LDA_ABX, 8'h00, 8'h03,
             c6step_pkg::OP_STA_ABS, 8'h00, 8'h03,
             c6step_pkg::OP_STX_ABS, 8'hFF, 8'hFF, c6step_pkg::OP_BNE, 8'h02,
             c6step_pkg::OP_BRK, c6step_pkg::OP_BRK, c6step_pkg::OP_BEQ, 8'hFE,
             c6step_pkg::OP_BCS, 8'h00, c6step_pkg::OP_BCC, 8'h80,
             c6step_pkg::OP_JSR, 8'h33, 8'h02, c6step_pkg::OP_BRK,
             c6step_pkg::OP_JMP, 8'h38, 8'h02, c6step_pkg::OP_RTS, c6step_pkg::OP_BRK,
             c6step_pkg::OP_BRK, c6step_pkg::OP_BRK, c6step_pkg::OP_BRK, 8'h02};
    load_and_run(16'h0200, 32);
    prog = '{8'hFF};
    load_and_run(16'hFFFF, 2);

    holdoff_req = 1;
    while (items_sent < 800) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        base = 16'($urandom);
        prog.delete();
        n = $urandom_range(1, 8);
        repeat (n) add_random_instr(base);
        load_and_run(base, n + $urandom_range(0, 4));
      end else begin
        case ($urandom_range(0, 3))
          0: send(c6step_pkg::CMD_WRITE, 16'($urandom), 8'($urandom));
          1: send(c6step_pkg::CMD_READ, 16'($urandom), 8'($urandom));
          2: send(c6step_pkg::CMD_START, 16'($urandom), 8'($urandom));
          default: send(c6step_pkg::CMD_STEP, 16'($urandom), 8'($urandom));
        endcase
      end
    end
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
+incdir+hdl
hdl/c6step_pkg.sv
hdl/c6step_ram.sv
hdl/c6step_seq.sv
hdl/cpu6502_subset_instruction_step.sv
tb/testbench.sv
